// ===== rtl/sliding_infinite_fourier_bank_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sliding Fourier bank
// Shared wrappers for concurrent checks, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef SLIDING_INFINITE_FOURIER_BANK_MACROS_SVH
`define SLIDING_INFINITE_FOURIER_BANK_MACROS_SVH

// Implication check that holds in the same cycle.
`define SIFB_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Implication check in the next cycle.
`define SIFB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/sifb_pkg.sv =====
// ----------------------------------------------------------------------------
// sifb_pkg
// Sizes, codes and state encoding for the sliding Fourier bank.
// ----------------------------------------------------------------------------
package sifb_pkg;

  localparam int NUM_BANDS   = 32;
  localparam int MAX_ORDER   = 8;
  localparam int BAND_W      = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int ORD_W       = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int STAGE_AW    = BAND_W + ORD_W;
  localparam int STAGE_DEPTH = NUM_BANDS * (2 ** ORD_W);

  localparam int SMP_W   = 16;
  localparam int COEF_W  = 18;
  localparam int VAL_W   = 24;
  localparam int PEAK_W  = 48;
  localparam int MAG_W   = 24;
  localparam int CFG_W   = 6;
  localparam int BANDF_W = 5;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_EMIT   = 2'd2
  } cmd_t;

  typedef enum logic {
    CFG_ACTIVE_BANDS = 1'b0,
    CFG_ACTIVE_ORDER = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CF,
    S_RD,
    S_MUL,
    S_WAIT,
    S_PW,
    S_PK,
    S_SQ,
    S_SQW,
    S_PUT
  } state_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] cos_c;
    logic signed [COEF_W-1:0] sin_c;
    logic        [COEF_W-1:0] decay;
  } coef_t;

endpackage

// ===== rtl/sifb_if.sv =====
// ----------------------------------------------------------------------------
// sifb channels
// Valid/ready channels for sample items and result beats.
// ----------------------------------------------------------------------------
interface sifb_in_if
  import sifb_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [BANDF_W-1:0]       band;
  logic signed [SMP_W-1:0]  sample;
  logic signed [COEF_W-1:0] cos_coef;
  logic signed [COEF_W-1:0] sin_coef;
  logic [COEF_W-1:0]        decay;

  modport source(output valid, cmd, band, sample, cos_coef, sin_coef, decay, input ready);
  modport sink(input valid, cmd, band, sample, cos_coef, sin_coef, decay, output ready);
endinterface

interface sifb_out_if
  import sifb_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [BANDF_W-1:0] band_index;
  logic [MAG_W-1:0]   magnitude;
  logic               last;

  modport source(output valid, band_index, magnitude, last, input ready);
  modport sink(input valid, band_index, magnitude, last, output ready);
endinterface

// ===== rtl/sifb_stage_ram.sv =====
// ----------------------------------------------------------------------------
// sifb_stage_ram
// Resonator state memory, one x/y pair per band and stage, reads zero
// until an entry is first written.
// ----------------------------------------------------------------------------
module sifb_stage_ram
  import sifb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  re,
  input  logic [STAGE_AW-1:0]   raddr,
  input  logic                  we,
  input  logic [STAGE_AW-1:0]   waddr,
  input  logic [2*VAL_W-1:0]    wdata,
  output logic [2*VAL_W-1:0]    rdata
);

  logic [2*VAL_W-1:0] mem [STAGE_DEPTH];
  logic [STAGE_DEPTH-1:0] written;
  logic [2*VAL_W-1:0] rd;
  logic               rd_ok;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      if (re) begin
        rd_ok <= written[raddr];
      end
    end
  end

  assign rdata = rd_ok ? rd : '0;

endmodule

// ===== rtl/sifb_resonator.sv =====
// ----------------------------------------------------------------------------
// sifb_resonator
// One resonator stage: rotate, decay, mix input, round and saturate.
// Four register stages from start to done.
// ----------------------------------------------------------------------------
module sifb_resonator
  import sifb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [VAL_W-1:0]  vx,
  input  logic signed [VAL_W-1:0]  vy,
  input  logic signed [VAL_W-1:0]  cx,
  input  logic signed [VAL_W-1:0]  cy,
  input  coef_t                    coef,
  output logic                     done,
  output logic signed [VAL_W-1:0]  nx,
  output logic signed [VAL_W-1:0]  ny
);

  localparam int P_W  = VAL_W + COEF_W;      // 42
  localparam int R_W  = P_W + 1;             // 43
  localparam int K_W  = COEF_W + 2;          // signed keep
  localparam int I_W  = VAL_W + K_W;         // 44
  localparam int H_W  = COEF_W / 2;          // decay split
  localparam int L_W  = R_W + H_W + 1;
  localparam int A_W  = 64;
  localparam int SH   = 34;

  logic [3:0] vld;

  logic signed [P_W-1:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [I_W-1:0] ix1, iy1, ix2, iy2, ix3, iy3;
  logic [COEF_W-1:0]     d1, d2;
  logic signed [R_W-1:0] rx, ry;
  logic signed [L_W-1:0] xl, xh, yl, yh;

  logic signed [K_W-1:0] keep;
  logic signed [A_W-1:0] ax, ay;
  logic signed [A_W-SH-1:0] qx, qy;

  function automatic logic signed [VAL_W-1:0] sat(input logic signed [A_W-SH-1:0] q);
    logic signed [A_W-SH-1:0] hi, lo;
    hi = (A_W-SH)'(2 ** (VAL_W-1) - 1);
    lo = -(A_W-SH)'(2 ** (VAL_W-1));
    if (q > hi) begin
      return VAL_W'(hi);
    end else if (q < lo) begin
      return VAL_W'(lo);
    end
    return q[VAL_W-1:0];
  endfunction

  assign keep = K_W'(2 ** COEF_W) - $signed({2'b00, coef.decay});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    // products of rotation and input mix
    p_xc <= vx * coef.cos_c;
    p_ys <= vy * coef.sin_c;
    p_xs <= vx * coef.sin_c;
    p_yc <= vy * coef.cos_c;
    ix1  <= cx * keep;
    iy1  <= cy * keep;
    d1   <= coef.decay;
    // rotated vector
    rx   <= R_W'(p_xc) - R_W'(p_ys);
    ry   <= R_W'(p_xs) + R_W'(p_yc);
    ix2  <= ix1;
    iy2  <= iy1;
    d2   <= d1;
    // decay as two half-width partial products
    xl   <= rx * $signed({1'b0, d2[H_W-1:0]});
    xh   <= rx * $signed({1'b0, d2[COEF_W-1:H_W]});
    yl   <= ry * $signed({1'b0, d2[H_W-1:0]});
    yh   <= ry * $signed({1'b0, d2[COEF_W-1:H_W]});
    ix3  <= ix2;
    iy3  <= iy2;
    // round half up, saturate
    nx   <= sat(qx);
    ny   <= sat(qy);
  end

  assign ax = (A_W'(xh) <<< H_W) + A_W'(xl) + (A_W'(ix3) <<< 16) + (A_W'(1) <<< (SH-1));
  assign ay = (A_W'(yh) <<< H_W) + A_W'(yl) + (A_W'(iy3) <<< 16) + (A_W'(1) <<< (SH-1));
  assign qx = ax[A_W-1:SH];
  assign qy = ay[A_W-1:SH];

  assign done = vld[3];

endmodule

// ===== rtl/sifb_isqrt.sv =====
// ----------------------------------------------------------------------------
// sifb_isqrt
// Integer square root, one result bit per cycle, restoring method.
// ----------------------------------------------------------------------------
module sifb_isqrt
  import sifb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PEAK_W-1:0]  value,
  output logic               busy,
  output logic               done,
  output logic [MAG_W-1:0]   root
);

  localparam int REM_W = MAG_W + 2;
  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [PEAK_W-1:0] val;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W+1:0]  shifted;
  logic [REM_W+1:0]  trial;

  assign shifted = {rem, val[PEAK_W-1 -: 2]};
  assign trial   = (REM_W+2)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MAG_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val <= {val[PEAK_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem  <= REM_W'(shifted - trial);
        root <= {root[MAG_W-2:0], 1'b1};
      end else begin
        rem  <= REM_W'(shifted);
        root <= {root[MAG_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/sliding_infinite_fourier_bank.sv =====
// ----------------------------------------------------------------------------
// sliding_infinite_fourier_bank
// Bank of cascaded complex one-pole resonators with per-band peak tracking.
//
// Usage:
//  - samples channel takes command beats: load (band coefficients), sample
//    (one mono Q1.15 value), emit (report peaks and clear them).
//  - results channel gives one beat per active band after an emit, in band
//    order, last set on the final band.
//  - cfg_we/cfg_index/cfg_data write active_bands and active_order; write
//    only while the block is idle.
// Processing:
//  - a sample runs one resonator stage at a time through the stage memory
//    read, a four-register arithmetic pipe and the write back, for each
//    active stage of each active band; samples.ready stays low until idle.
//  - emit is paced by the bit-serial square root, one band at a time.
// Reset clears state memory valid bits, peaks and registers (32 bands,
// order 4); coefficients stay undefined until loaded. A stalled receiver
// holds the result register and the emit walk waits on it.
// ----------------------------------------------------------------------------
`include "sliding_infinite_fourier_bank_macros.svh"

module sliding_infinite_fourier_bank
  import sifb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  sifb_in_if.sink           samples,
  sifb_out_if.source        results,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  state_t state, state_next;

  logic [5:0] active_bands;
  logic [3:0] active_order;
  logic [BAND_W-1:0] nb_last;
  logic [ORD_W-1:0]  no_last;

  logic [BAND_W-1:0] band_cnt;
  logic [ORD_W-1:0]  ord_cnt;
  logic signed [SMP_W-1:0] smp;
  logic signed [VAL_W-1:0] cur_x, cur_y;
  logic signed [PEAK_W-1:0] sq_x, sq_y;
  logic [PEAK_W-1:0] pw;
  logic [PEAK_W-1:0] peak [NUM_BANDS];

  // coefficient memory, one entry per band
  coef_t coef_mem [NUM_BANDS];
  coef_t coef_rd;

  logic acc, out_free, is_last_band;
  logic cf_re, st_re, res_start, sq_start;
  logic st_we;
  logic res_done, sq_busy, sq_done;
  logic signed [VAL_W-1:0] nx, ny, vx, vy;
  logic [2*VAL_W-1:0] st_rdata;
  logic [MAG_W-1:0] root;

  // effective register values, out-of-range clamped
  always_comb begin
    if (active_bands == '0) begin
      nb_last = '0;
    end else if (32'(active_bands) > NUM_BANDS) begin
      nb_last = BAND_W'(NUM_BANDS - 1);
    end else begin
      nb_last = BAND_W'(active_bands - 1'b1);
    end
    if (active_order == '0) begin
      no_last = '0;
    end else if (32'(active_order) > MAX_ORDER) begin
      no_last = ORD_W'(MAX_ORDER - 1);
    end else begin
      no_last = ORD_W'(active_order - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bands <= 6'd32;
      active_order <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE_BANDS: active_bands <= cfg_data[5:0];
        CFG_ACTIVE_ORDER: active_order <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign samples.ready = (state == S_IDLE);
  assign acc           = samples.valid && samples.ready;
  assign out_free      = !results.valid || results.ready;
  assign is_last_band  = (band_cnt == nb_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cf_re      = 1'b0;
    st_re      = 1'b0;
    res_start  = 1'b0;
    sq_start   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          case (samples.cmd)
            CMD_SAMPLE: state_next = S_CF;
            CMD_EMIT:   state_next = S_SQ;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_CF: begin
        cf_re      = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        st_re      = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        res_start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (res_done) begin
          state_next = (ord_cnt == no_last) ? S_PW : S_RD;
        end
      end
      S_PW: state_next = S_PK;
      S_PK: state_next = is_last_band ? S_IDLE : S_CF;
      S_SQ: begin
        sq_start   = 1'b1;
        state_next = S_SQW;
      end
      S_SQW: begin
        if (sq_done) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (out_free) begin
          state_next = is_last_band ? S_IDLE : S_SQ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // coefficient load and read
  always_ff @(posedge clk) begin
    if (acc && samples.cmd == CMD_LOAD && 32'(samples.band) < NUM_BANDS) begin
      coef_mem[BAND_W'(samples.band)] <= '{cos_c: samples.cos_coef,
                                           sin_c: samples.sin_coef,
                                           decay: samples.decay};
    end
    if (cf_re) begin
      coef_rd <= coef_mem[band_cnt];
    end
  end

  assign st_we = (state == S_WAIT) && res_done;

  // squares of the last stage output, 24x24 each
  assign sq_x = cur_x * cur_x;
  assign sq_y = cur_y * cur_y;

  // walk counters, stage chaining, peak power
  always_ff @(posedge clk) begin
    if (acc) begin
      band_cnt <= '0;
      ord_cnt  <= '0;
      smp      <= samples.sample;
    end
    if (state == S_CF) begin
      // first stage of each band is driven by the sample, Q2.22
      cur_x <= VAL_W'(smp) <<< 7;
      cur_y <= '0;
    end
    if (st_we) begin
      cur_x   <= nx;
      cur_y   <= ny;
      ord_cnt <= (ord_cnt == no_last) ? '0 : ord_cnt + 1'b1;
    end
    if (state == S_PW) begin
      pw <= $unsigned(sq_x) + $unsigned(sq_y);
    end
    if (state == S_PK) begin
      band_cnt <= band_cnt + 1'b1;
    end
    if (state == S_PUT && out_free) begin
      band_cnt <= band_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        peak[i] <= '0;
      end
    end else if (state == S_PK) begin
      if (pw > peak[band_cnt]) begin
        peak[band_cnt] <= pw;
      end
    end else if (state == S_PUT && out_free && is_last_band) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        peak[i] <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == S_PUT && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUT && out_free) begin
      results.band_index <= BANDF_W'(band_cnt);
      results.magnitude  <= root;
      results.last       <= is_last_band;
    end
  end

  assign vx = st_rdata[2*VAL_W-1:VAL_W];
  assign vy = st_rdata[VAL_W-1:0];

  sifb_stage_ram u_stage_ram (
    .clk   (clk),
    .rst   (rst),
    .re    (st_re),
    .raddr ({band_cnt, ord_cnt}),
    .we    (st_we),
    .waddr ({band_cnt, ord_cnt}),
    .wdata ({nx, ny}),
    .rdata (st_rdata)
  );

  sifb_resonator u_resonator (
    .clk   (clk),
    .rst   (rst),
    .start (res_start),
    .vx    (vx),
    .vy    (vy),
    .cx    (cur_x),
    .cy    (cur_y),
    .coef  (coef_rd),
    .done  (res_done),
    .nx    (nx),
    .ny    (ny)
  );

  sifb_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (peak[band_cnt]),
    .busy  (sq_busy),
    .done  (sq_done),
    .root  (root)
  );

  `SIFB_ASSERT_IMP(a_res_done_wait, res_done, state == S_WAIT, "stage result outside wait")
  `SIFB_ASSERT_IMP(a_wr_band_range, st_we, band_cnt <= nb_last, "stage write past last band")
  `SIFB_ASSERT_NEXT(a_sq_runs, sq_start, sq_busy, "square root did not start")
  `SIFB_ASSERT_IMP(a_last_band, results.valid && results.last,
                   results.band_index == BANDF_W'(nb_last), "last flag on wrong band")

endmodule
